>>> sv/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg)
`define ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg)
`endif
`endif

>>> sv/tdl_pkg.sv
`default_nettype none
package tdl_pkg;
	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_ZC    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] VAL_MAX  = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] VAL_MIN  = 64'h8000_0000_0000_0000;

	localparam int IP_CNTW = 6;
	localparam logic [IP_CNTW-1:0] MUL_LAST = 6'd4;
	localparam logic [IP_CNTW-1:0] DIV_LAST = 6'd63;

	typedef enum logic [1:0] {
		RD_NEWEST,
		RD_OLDEST,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_KEEP,
		RES_SAMPLE,
		RES_RDV,
		RES_PREV,
		RES_ZC,
		RES_NEGZC,
		RES_TRIV,
		RES_SUM
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mem_rd;
		rd_sel_t  rd_sel;
		logic     mem_wr;
		logic     dec_fill;
		logic     drop_one;
		logic     inc_fill;
		logic     drop_row;
		logic     set_dup;
		logic     scan_init;
		logic     scan_eval;
		logic     ip_load_row;
		logic     ip_load_last;
		logic     ip_chk;
		logic     mul_step;
		logic     div_ones;
		logic     div_init;
		logic     div_step;
		res_sel_t res_sel;
		logic     st_range;
		logic     st_ovf;
		logic     ev_scan;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       ch_ok;
		logic       bad_delay;
		logic       early;
		logic       in_window;
		logic       empty;
		logic       full;
		logic       fill_one;
		logic       rb_more;
		logic       dup;
		logic       dup_q;
		logic       ts_gt_last;
		logic       scan_done;
		logic       sev;
		logic       row_last;
		logic       triv;
		logic       mul_last;
		logic       ovf;
		logic       div_last;
	} dp_sts_t;
endpackage
`default_nettype wire

>>> sv/tdl_ctrl.sv
`default_nettype none
module tdl_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  tdl_pkg::dp_sts_t  sts,
	output tdl_pkg::dp_cmd_t  cmd
);
	import tdl_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE      = 20'b0000_0000_0000_0000_0001,
		S_DISP      = 20'b0000_0000_0000_0000_0010,
		S_RB_RD     = 20'b0000_0000_0000_0000_0100,
		S_RB_EV     = 20'b0000_0000_0000_0000_1000,
		S_APPEND    = 20'b0000_0000_0000_0001_0000,
		S_WRITE     = 20'b0000_0000_0000_0010_0000,
		S_SCAN_INIT = 20'b0000_0000_0000_0100_0000,
		S_SCAN_RD   = 20'b0000_0000_0000_1000_0000,
		S_SCAN_EV   = 20'b0000_0000_0001_0000_0000,
		S_SCAN_END  = 20'b0000_0000_0010_0000_0000,
		S_OLD_RD    = 20'b0000_0000_0100_0000_0000,
		S_OLD_EV    = 20'b0000_0000_1000_0000_0000,
		S_LAST_RD   = 20'b0000_0001_0000_0000_0000,
		S_LAST_EV   = 20'b0000_0010_0000_0000_0000,
		S_IP_CHK    = 20'b0000_0100_0000_0000_0000,
		S_MUL       = 20'b0000_1000_0000_0000_0000,
		S_DIV_CHK   = 20'b0001_0000_0000_0000_0000,
		S_DIV       = 20'b0010_0000_0000_0000_0000,
		S_SUM       = 20'b0100_0000_0000_0000_0000,
		S_FIN       = 20'b1000_0000_0000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				if (!sts.ch_ok) begin
					state_d = S_FIN;
				end else begin
					case (sts.op)
						OP_STORE: state_d = sts.empty ? S_APPEND : S_RB_RD;
						OP_READ: begin
							if (sts.bad_delay) begin
								cmd.res_sel  = RES_SAMPLE;
								cmd.st_range = 1'b1;
								state_d      = S_FIN;
							end else if (sts.early || sts.empty) begin
								cmd.res_sel = RES_SAMPLE;
								state_d     = S_FIN;
							end else if (sts.in_window) begin
								state_d = S_OLD_RD;
							end else begin
								state_d = S_LAST_RD;
							end
						end
						OP_ZC: begin
							cmd.res_sel = RES_ZC;
							state_d     = sts.empty ? S_FIN : S_SCAN_INIT;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_RB_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_NEWEST;
				state_d    = S_RB_EV;
			end
			S_RB_EV: begin
				if (sts.rb_more) begin
					cmd.dec_fill = 1'b1;
					state_d      = sts.fill_one ? S_APPEND : S_RB_RD;
				end else if (sts.dup) begin
					cmd.set_dup = 1'b1;
					state_d     = S_SCAN_INIT;
				end else begin
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				if (sts.full) begin
					cmd.drop_one = 1'b1;
					cmd.st_ovf   = 1'b1;
				end
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.mem_wr   = 1'b1;
				cmd.inc_fill = 1'b1;
				state_d      = S_SCAN_INIT;
			end
			S_SCAN_INIT: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_SCAN;
				state_d    = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				state_d       = sts.scan_done ? S_SCAN_END : S_SCAN_RD;
			end
			S_SCAN_END: begin
				state_d = S_FIN;
				case (sts.op)
					OP_STORE: begin
						cmd.drop_row = sts.dup_q || !sts.sev;
						cmd.ev_scan  = !sts.dup_q;
					end
					OP_ZC: begin
						cmd.ev_scan = 1'b1;
						if (sts.sev) cmd.res_sel = RES_NEGZC;
					end
					OP_READ: begin
						if (sts.row_last) begin
							cmd.res_sel = RES_PREV;
						end else begin
							cmd.ip_load_row = 1'b1;
							state_d         = S_IP_CHK;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_OLD_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_OLDEST;
				state_d    = S_OLD_EV;
			end
			S_OLD_EV: begin
				cmd.res_sel = RES_RDV;
				state_d     = S_FIN;
			end
			S_LAST_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_NEWEST;
				state_d    = S_LAST_EV;
			end
			S_LAST_EV: begin
				if (sts.ts_gt_last) begin
					cmd.ip_load_last = 1'b1;
					state_d          = S_IP_CHK;
				end else begin
					state_d = S_SCAN_INIT;
				end
			end
			S_IP_CHK: begin
				cmd.ip_chk = 1'b1;
				if (sts.triv) begin
					cmd.res_sel = RES_TRIV;
					state_d     = S_FIN;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = S_DIV_CHK;
			end
			S_DIV_CHK: begin
				if (sts.ovf) begin
					cmd.div_ones = 1'b1;
					state_d      = S_SUM;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_SUM;
			end
			S_SUM: begin
				cmd.res_sel = RES_SUM;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> sv/tdl_dp.sv
`default_nettype none
module tdl_dp #(
	parameter int CHANNELS = 4,
	parameter int DEPTH    = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire signed [63:0]  cfg_data,
	input  wire        [1:0]   op,
	input  wire        [1:0]   channel,
	input  wire signed [63:0]  now_time,
	input  wire signed [63:0]  sample_value,
	input  wire        [62:0]  delay_amount,
	input  wire        [62:0]  delay_limit,
	input  wire signed [63:0]  zc_value,
	input  tdl_pkg::dp_cmd_t   cmd,
	output tdl_pkg::dp_sts_t   sts,
	output logic signed [63:0] result_value,
	output logic               event_found,
	output logic       [1:0]   status
);
	import tdl_pkg::*;

	localparam int ENTRIES = CHANNELS * DEPTH;
	localparam int IDXW    = $clog2(DEPTH);
	localparam int CNTW    = $clog2(DEPTH + 1);
	localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDXW:0]   DEPTH_X = (IDXW + 1)'(DEPTH);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);
	localparam logic [AW-1:0]   DEPTH_A = AW'(DEPTH);

	function automatic logic [IDXW-1:0] wrap_add(input logic [IDXW-1:0] a,
		input logic [IDXW-1:0] b);
		logic [IDXW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_X) s = s - DEPTH_X;
		return s[IDXW-1:0];
	endfunction

	logic        [1:0]  op_q, ch_q;
	logic signed [63:0] now_q, sample_q, zc_q, ts_q, start_q;
	logic        [62:0] delay_q, limit_q;
	logic               dup_q;

	logic [IDXW-1:0] head_q [CHANNELS];
	logic [CNTW-1:0] fill_q [CHANNELS];

	logic signed [63:0] time_mem [ENTRIES];
	logic signed [63:0] val_mem  [ENTRIES];
	logic signed [63:0] rd_t_q, rd_v_q;

	logic [IDXW-1:0]    p_q, row_q;
	logic               sev_q, sev_done_q, row_last_q;
	logic signed [63:0] prev_t_q, prev_v_q, cur_t_q, cur_v_q;

	logic signed [63:0] t0_q, v0_q, t1_q, v1_q;
	logic        [63:0] dv_q, dx_q, dt_q, prod_q, rem_q, lo_q, quo_q;
	logic               nd_q, nt_q;
	logic       [127:0] acc_q;
	logic [IP_CNTW-1:0] cnt_q;

	logic signed [63:0] res_q;
	logic               evr_q;
	logic        [1:0]  st_q;

	// saturated time arithmetic at capture
	logic [64:0] ts_x, win_x;
	logic [63:0] ts_c, win_c;
	assign ts_x  = {now_time[63], now_time} - {2'b00, delay_amount};
	assign ts_c  = (ts_x[64] && !ts_x[63]) ? VAL_MIN : ts_x[63:0];
	assign win_x = {start_q[63], start_q} + {2'b00, delay_q};
	assign win_c = (!win_x[64] && win_x[63]) ? VAL_MAX : win_x[63:0];

	logic [CHW-1:0]  chi;
	logic [IDXW-1:0] head_c, rd_k, wr_k;
	logic [CNTW-1:0] fill_c;
	logic [AW-1:0]   base, rd_addr, wr_addr;

	assign chi    = CHW'(ch_q);
	assign head_c = head_q[chi];
	assign fill_c = fill_q[chi];
	assign base   = AW'(chi) * DEPTH_A;
	assign wr_k   = IDXW'(fill_c);

	always_comb begin
		case (cmd.rd_sel)
			RD_NEWEST: rd_k = IDXW'(fill_c - 1'b1);
			RD_SCAN:   rd_k = p_q;
			default:   rd_k = '0;
		endcase
	end

	assign rd_addr = base + AW'(wrap_add(head_c, rd_k));
	assign wr_addr = base + AW'(wrap_add(head_c, wr_k));

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			time_mem[wr_addr] <= now_q;
			val_mem[wr_addr]  <= sample_q;
		end
		if (cmd.mem_rd) begin
			rd_t_q <= time_mem[rd_addr];
			rd_v_q <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) start_q <= cfg_data;
			if (cmd.dec_fill) begin
				fill_q[chi] <= fill_c - 1'b1;
			end else if (cmd.drop_one) begin
				head_q[chi] <= wrap_add(head_c, IDXW'(1));
				fill_q[chi] <= fill_c - 1'b1;
			end else if (cmd.inc_fill) begin
				fill_q[chi] <= fill_c + 1'b1;
			end else if (cmd.drop_row) begin
				head_q[chi] <= wrap_add(head_c, row_q);
				fill_q[chi] <= fill_c - CNTW'(row_q);
			end
		end
	end

	// capture of the input transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			ch_q     <= channel;
			now_q    <= now_time;
			sample_q <= sample_value;
			delay_q  <= delay_amount;
			limit_q  <= delay_limit;
			zc_q     <= zc_value;
			ts_q     <= ts_c;
			dup_q    <= 1'b0;
		end else if (cmd.set_dup) begin
			dup_q <= 1'b1;
		end
	end

	// row and event walk
	logic gt_c, last_p_c;
	assign gt_c     = rd_t_q > ts_q;
	assign last_p_c = (CNTW'(p_q) == fill_c - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			p_q <= '0;
		end else if (cmd.scan_eval) begin
			if (p_q == '0) begin
				prev_t_q   <= rd_t_q;
				prev_v_q   <= rd_v_q;
				row_q      <= '0;
				sev_q      <= 1'b0;
				sev_done_q <= gt_c;
				row_last_q <= 1'b1;
			end else begin
				if (!sev_done_q) begin
					if (prev_t_q == rd_t_q) begin
						sev_q      <= 1'b1;
						sev_done_q <= 1'b1;
					end else if (gt_c) begin
						sev_done_q <= 1'b1;
					end
				end
				if (gt_c) begin
					cur_t_q    <= rd_t_q;
					cur_v_q    <= rd_v_q;
					row_last_q <= 1'b0;
				end else begin
					prev_t_q   <= rd_t_q;
					prev_v_q   <= rd_v_q;
					row_q      <= p_q;
					row_last_q <= 1'b1;
				end
			end
			p_q <= p_q + 1'b1;
		end
	end

	// interpolation operands and checks
	logic [63:0] dv_c, dx_c, dt_c;
	logic        nd_c, nt_c, triv_c;
	logic signed [63:0] triv_v;

	assign nd_c = v1_q < v0_q;
	assign nt_c = ts_q < t0_q;
	assign dv_c = nd_c ? 64'(v0_q - v1_q) : 64'(v1_q - v0_q);
	assign dx_c = nt_c ? 64'(t0_q - ts_q) : 64'(ts_q - t0_q);
	assign dt_c = 64'(t1_q - t0_q);

	always_comb begin
		triv_c = 1'b1;
		triv_v = v0_q;
		if (ts_q == t0_q) triv_v = v0_q;
		else if (ts_q == t1_q) triv_v = v1_q;
		else if (t1_q <= t0_q) triv_v = v0_q;
		else if (dv_c == '0 || dx_c == '0) triv_v = v0_q;
		else triv_c = 1'b0;
	end

	logic [31:0]  ma, mb;
	logic [63:0]  mp;
	logic [6:0]   shamt;
	logic [127:0] addend;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin ma = dv_q[31:0];  mb = dx_q[31:0];  end
			2'd1: begin ma = dv_q[31:0];  mb = dx_q[63:32]; end
			2'd2: begin ma = dv_q[63:32]; mb = dx_q[31:0];  end
			default: begin ma = dv_q[63:32]; mb = dx_q[63:32]; end
		endcase
		case (cnt_q) inside
			6'd1:       shamt = 7'd0;
			6'd2, 6'd3: shamt = 7'd32;
			default:    shamt = 7'd64;
		endcase
	end

	assign mp     = ma * mb;
	assign addend = {64'd0, prod_q} << shamt;

	logic        div_top, div_ge;
	logic [63:0] rem2;
	assign div_top = rem_q[63];
	assign rem2    = {rem_q[62:0], lo_q[63]};
	assign div_ge  = div_top || (rem2 >= dt_q);

	always_ff @(posedge clk) begin
		if (cmd.ip_load_row) begin
			t0_q <= prev_t_q;
			v0_q <= prev_v_q;
			t1_q <= cur_t_q;
			v1_q <= cur_v_q;
		end else if (cmd.ip_load_last) begin
			t0_q <= rd_t_q;
			v0_q <= rd_v_q;
			t1_q <= now_q;
			v1_q <= sample_q;
		end
		if (cmd.ip_chk) begin
			dv_q  <= dv_c;
			dx_q  <= dx_c;
			dt_q  <= dt_c;
			nd_q  <= nd_c;
			nt_q  <= nt_c;
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.mul_step) begin
			if (cnt_q != MUL_LAST) prod_q <= mp;
			if (cnt_q != '0) acc_q <= acc_q + addend;
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.div_ones) begin
			quo_q <= '1;
		end else if (cmd.div_init) begin
			rem_q <= acc_q[127:64];
			lo_q  <= acc_q[63:0];
			quo_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? rem2 - dt_q : rem2;
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], div_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// saturated offset from the left value
	logic [63:0] u_c, sum_v;
	logic [64:0] sum_x;
	assign u_c   = v0_q ^ SIGN_BIT;
	assign sum_x = {1'b0, u_c} + {1'b0, quo_q};

	always_comb begin
		if (nd_q == nt_q) sum_v = sum_x[64] ? VAL_MAX : (sum_x[63:0] ^ SIGN_BIT);
		else sum_v = (quo_q > u_c) ? VAL_MIN : ((u_c - quo_q) ^ SIGN_BIT);
	end

	logic signed [63:0] negzc;
	assign negzc = (zc_q == VAL_MIN) ? VAL_MAX : -zc_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q <= '0;
			evr_q <= 1'b0;
			st_q  <= ST_OK;
		end else begin
			case (cmd.res_sel)
				RES_SAMPLE: res_q <= sample_q;
				RES_RDV:    res_q <= rd_v_q;
				RES_PREV:   res_q <= prev_v_q;
				RES_ZC:     res_q <= zc_q;
				RES_NEGZC:  res_q <= negzc;
				RES_TRIV:   res_q <= triv_v;
				RES_SUM:    res_q <= sum_v;
				default:    res_q <= res_q;
			endcase
			if (cmd.st_range) st_q <= ST_RANGE;
			else if (cmd.st_ovf) st_q <= ST_OVF;
			if (cmd.ev_scan) evr_q <= sev_q;
		end
		if (cmd.out_load) begin
			result_value <= res_q;
			event_found  <= evr_q;
			status       <= st_q;
		end
	end

	assign sts.op         = op_q;
	assign sts.ch_ok      = 32'(ch_q) < 32'(CHANNELS);
	assign sts.bad_delay  = (delay_q == '0) || (delay_q > limit_q);
	assign sts.early      = now_q <= start_q;
	assign sts.in_window  = now_q <= $signed(win_c);
	assign sts.empty      = fill_c == '0;
	assign sts.full       = fill_c == DEPTH_C;
	assign sts.fill_one   = fill_c == CNTW'(1);
	assign sts.rb_more    = now_q < rd_t_q;
	assign sts.dup        = (rd_t_q == now_q) && (rd_v_q == sample_q);
	assign sts.dup_q      = dup_q;
	assign sts.ts_gt_last = ts_q > rd_t_q;
	assign sts.scan_done  = ((p_q != '0) && gt_c) || last_p_c;
	assign sts.sev        = sev_q;
	assign sts.row_last   = row_last_q;
	assign sts.triv       = triv_c;
	assign sts.mul_last   = cnt_q == MUL_LAST;
	assign sts.ovf        = acc_q[127:64] >= dt_q;
	assign sts.div_last   = cnt_q == DIV_LAST;
endmodule
`default_nettype wire

>>> sv/timestamped_delay_line_interp.sv
`default_nettype none
`include "assert_macros.svh"
// Variable transport delay over CHANNELS buffers of DEPTH (time, value) pairs, Q32.32 throughout.
// One item is handled at a time and gives one result. The cost is set by the buffer
// memory, whose read is registered: each entry walked (rollback of newer entries or
// the row search) takes a read state and an evaluate state, so the time for an item
// grows with the number of entries walked. An interpolation adds a multiply built from
// 32x32 partial products and a bit-serial division, skipped when the quotient saturates.
// The memory needs no clearing after reset; the fill counts mark what is valid. A
// finished result sits in the output register while the next item is accepted.
module timestamped_delay_line_interp #(
	parameter int CHANNELS = 4,
	parameter int DEPTH    = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire signed [63:0]  cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire        [1:0]   op,
	input  wire        [1:0]   channel,
	input  wire signed [63:0]  now_time,
	input  wire signed [63:0]  sample_value,
	input  wire        [62:0]  delay_amount,
	input  wire        [62:0]  delay_limit,
	input  wire signed [63:0]  zc_value,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [63:0] result_value,
	output logic               event_found,
	output logic       [1:0]   status
);
	import tdl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	tdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdl_dp #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.op           (op),
		.channel      (channel),
		.now_time     (now_time),
		.sample_value (sample_value),
		.delay_amount (delay_amount),
		.delay_limit  (delay_limit),
		.zc_value     (zc_value),
		.cmd          (cmd),
		.sts          (sts),
		.result_value (result_value),
		.event_found  (event_found),
		.status       (status)
	);

	// busy once a transfer is taken
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`ASSERT_IMPL(a_range_no_event, clk, arst_n, out_valid && status == ST_RANGE, !event_found, "event on range error")
	`ASSERT_IMPL(a_status_code, clk, arst_n, out_valid, status == ST_OK || status == ST_RANGE || status == ST_OVF, "bad status")
	`ASSERT_IMPL(a_load_free, clk, arst_n, cmd.out_load, !out_valid || out_ready, "result overwritten")
endmodule
`default_nettype wire

>>> bench/tdl_scoreboard.sv
`timescale 1ns / 1ps
`default_nettype none
module tdl_scoreboard (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	input  wire               cfg_ready,
	input  wire signed [63:0] cfg_data,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire        [1:0]  op,
	input  wire        [1:0]  channel,
	input  wire signed [63:0] now_time,
	input  wire signed [63:0] sample_value,
	input  wire        [62:0] delay_amount,
	input  wire        [62:0] delay_limit,
	input  wire signed [63:0] zc_value,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire signed [63:0] result_value,
	input  wire               event_found,
	input  wire        [1:0]  status,
	output int                fails,
	output int                pending
);
	import tdl_pkg::*;

	localparam int DEPTH = 256;
	localparam longint LMAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint LMIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [63:0] value;
		logic               ev;
		logic [1:0]         st;
	} delayed_result_t;

	longint      pair_time [0:4*DEPTH-1];
	longint      pair_value[0:4*DEPTH-1];
	int unsigned head_ptr[4];
	int unsigned fill[4];
	longint      start_t;
	delayed_result_t awaited_q[$];

	function automatic int unsigned slot(int ch, int unsigned k);
		return ch * DEPTH + (head_ptr[ch] + k) % DEPTH;
	endfunction

	function automatic longint sat_sub(longint a, longint d);
		if (a < LMIN + d) return LMIN;
		return a - d;
	endfunction

	function automatic longint sat_add(longint a, longint d);
		if (a > LMAX - d) return LMAX;
		return a + d;
	endfunction

	function automatic int unsigned row_of(int ch, longint ts);
		int unsigned p;
		if (fill[ch] == 0 || ts < pair_time[slot(ch, 0)]) return 0;
		for (p = 1; p < fill[ch]; p++)
			if (pair_time[slot(ch, p)] > ts) return p - 1;
		return fill[ch] - 1;
	endfunction

	function automatic bit event_in_range(int ch, longint ts);
		int unsigned p;
		longint cur;
		if (fill[ch] == 0 || ts < pair_time[slot(ch, 0)]) return 0;
		for (p = 1; p < fill[ch]; p++) begin
			cur = pair_time[slot(ch, p)];
			if (pair_time[slot(ch, p - 1)] == cur) return 1;
			if (cur > ts) return 0;
		end
		return 0;
	endfunction

	function automatic void drop_oldest(int ch, int unsigned r);
		if (r > fill[ch]) r = fill[ch];
		head_ptr[ch] = (head_ptr[ch] + r) % DEPTH;
		fill[ch] -= r;
	endfunction

	function automatic longint lerp(longint t0, longint v0, longint t1, longint v1, longint ts);
		bit nd, nt;
		bit [63:0] dv, dx, dt, q, u;
		bit [127:0] prod;
		if (t0 == ts) return v0;
		if (t1 == ts) return v1;
		if (t1 <= t0) return v0;
		nd = v1 < v0;
		dv = nd ? v0 - v1 : v1 - v0;
		nt = ts < t0;
		dx = nt ? t0 - ts : ts - t0;
		dt = t1 - t0;
		if (dv == 0 || dx == 0) return v0;
		prod = {64'd0, dv} * {64'd0, dx};
		if (prod[127:64] >= dt) q = '1;
		else q = 64'(prod / {64'd0, dt});
		u = v0 ^ SIGN_BIT;
		if (nd == nt) begin
			if (q > ~u) return LMAX;
			u = u + q;
		end else begin
			if (q > u) return LMIN;
			u = u - q;
		end
		return longint'(u ^ SIGN_BIT);
	endfunction

	function automatic longint delayed_value(int ch, longint now, longint smp, longint dl);
		int unsigned n, i;
		longint ts, lt;
		n = fill[ch];
		if (now <= start_t || n == 0) return smp;
		if (now <= sat_add(start_t, dl)) return pair_value[slot(ch, 0)];
		ts = sat_sub(now, dl);
		lt = pair_time[slot(ch, n - 1)];
		if (ts > lt) return lerp(lt, pair_value[slot(ch, n - 1)], now, smp, ts);
		i = row_of(ch, ts);
		if (i + 1 >= n) return pair_value[slot(ch, i)];
		return lerp(pair_time[slot(ch, i)], pair_value[slot(ch, i)],
			pair_time[slot(ch, i + 1)], pair_value[slot(ch, i + 1)], ts);
	endfunction

	function automatic delayed_result_t predict(logic [1:0] o, int ch, longint now,
			longint smp, longint dl, longint lim, longint zc);
		delayed_result_t r;
		longint ts;
		int unsigned row;
		bit e;
		r = '0;
		ts = sat_sub(now, dl);
		case (o)
			OP_STORE: begin
				while (fill[ch] > 0 && now < pair_time[slot(ch, fill[ch] - 1)])
					fill[ch]--;
				if (fill[ch] > 0 && pair_time[slot(ch, fill[ch] - 1)] == now &&
						pair_value[slot(ch, fill[ch] - 1)] == smp) begin
					drop_oldest(ch, row_of(ch, ts));
				end else begin
					if (fill[ch] >= DEPTH) begin
						drop_oldest(ch, 1);
						r.st = ST_OVF;
					end
					pair_time[slot(ch, fill[ch])] = now;
					pair_value[slot(ch, fill[ch])] = smp;
					fill[ch]++;
					row = row_of(ch, ts);
					e = event_in_range(ch, ts);
					r.ev = e;
					if (row > 0 && !e) drop_oldest(ch, row);
				end
			end
			OP_READ: begin
				if (dl == 0 || dl > lim) begin
					r.value = smp;
					r.st = ST_RANGE;
				end else begin
					r.value = delayed_value(ch, now, smp, dl);
				end
			end
			OP_ZC: begin
				r.value = zc;
				if (fill[ch] > 0 && event_in_range(ch, ts)) begin
					r.ev = 1;
					r.value = (zc == LMIN) ? LMAX : -zc;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		delayed_result_t want;
		if (!arst_n) begin
			fails = 0;
			pending = 0;
			start_t = 0;
			awaited_q.delete();
			for (int c = 0; c < 4; c++) begin
				head_ptr[c] = 0;
				fill[c] = 0;
			end
		end else begin
			if (cfg_valid && cfg_ready)
				start_t = cfg_data;
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					$display("%0t: unexpected result value=%h ev=%0d st=%0d",
						$realtime, result_value, event_found, status);
					fails++;
				end else begin
					want = awaited_q.pop_front();
					if (result_value !== want.value) begin
						$display("%0t: result_value expected %h actual %h",
							$realtime, want.value, result_value);
						fails++;
					end
					if (event_found !== want.ev) begin
						$display("%0t: event_found expected %0d actual %0d",
							$realtime, want.ev, event_found);
						fails++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, want.st, status);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				awaited_q.push_back(predict(op, channel, now_time, sample_value,
					longint'({1'b0, delay_amount}), longint'({1'b0, delay_limit}),
					zc_value));
			pending = awaited_q.size();
		end
	end
endmodule
`default_nettype wire

>>> bench/tb_timestamped_delay_line_interp.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_timestamped_delay_line_interp;
	import tdl_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint ONE = 64'sh1_0000_0000;
	localparam longint LMAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint LMIN = 64'sh8000_0000_0000_0000;
	localparam logic [62:0] D_MAX = '1;
	localparam int STALL_LIMIT = 40000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic signed [63:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [1:0] channel = '0;
	logic signed [63:0] now_time = '0;
	logic signed [63:0] sample_value = '0;
	logic [62:0] delay_amount = '0;
	logic [62:0] delay_limit = '0;
	logic signed [63:0] zc_value = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [63:0] result_value;
	logic event_found;
	logic [1:0] status;
	int fails, pending;

	int send_idle = 0;
	int recv_stall = 0;
	int hold_reqs = 0;
	int quiet_cycles = 0;
	longint chan_time[4];
	longint chan_value[4];

	always #4 clk = ~clk;

	timestamped_delay_line_interp dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .channel(channel),
		.now_time(now_time), .sample_value(sample_value), .delay_amount(delay_amount),
		.delay_limit(delay_limit), .zc_value(zc_value),
		.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
		.event_found(event_found), .status(status)
	);

	tdl_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .channel(channel),
		.now_time(now_time), .sample_value(sample_value), .delay_amount(delay_amount),
		.delay_limit(delay_limit), .zc_value(zc_value),
		.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
		.event_found(event_found), .status(status),
		.fails(fails), .pending(pending)
	);

	// receiver side, with a long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				out_ready = 0;
				repeat (3000) @(negedge clk);
			end
			out_ready = ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint rand64();
		return longint'({$urandom, $urandom});
	endfunction

	function automatic logic [62:0] short_delay();
		return {29'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
	endfunction

	task automatic push_item(logic [1:0] o, logic [1:0] ch, longint now, longint smp,
			logic [62:0] dl, logic [62:0] lim, longint zc);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		op = o;
		channel = ch;
		now_time = now;
		sample_value = smp;
		delay_amount = dl;
		delay_limit = lim;
		zc_value = zc;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_start(longint v);
		drain();
		cfg_valid = 1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_item();
		logic [1:0] ch;
		int k;
		longint now, smp;
		logic [62:0] dl, lim;
		ch = 2'($urandom_range(0, 3));
		k = $urandom_range(99);
		dl = ($urandom_range(19) == 0) ? 63'({$urandom, $urandom}) : short_delay();
		lim = ($urandom_range(4) == 0) ? 63'({$urandom, $urandom}) : dl + short_delay();
		if ($urandom_range(19) == 0) dl = '0;
		if (k < 50) begin
			k = $urandom_range(99);
			smp = ($urandom_range(1) == 0) ? rand64() : longint'($urandom_range(0, 64)) * ONE;
			if (k < 4) now = rand64();
			else if (k < 12) now = chan_time[ch] - longint'($urandom_range(1, 4)) * ONE;
			else if (k < 22) now = chan_time[ch];
			else now = chan_time[ch] + longint'($urandom_range(0, 2)) * ONE + $urandom;
			if (k >= 22 && k < 30) begin
				now = chan_time[ch];
				smp = chan_value[ch];
			end
			chan_time[ch] = now;
			chan_value[ch] = smp;
			push_item(OP_STORE, ch, now, smp, dl, lim, rand64());
		end else begin
			now = chan_time[ch] + longint'($urandom_range(0, 2)) * ONE + $urandom;
			if (k < 80)
				push_item(OP_READ, ch, now, rand64(), dl, lim, rand64());
			else if (k < 96)
				push_item(OP_ZC, ch, now, rand64(), dl, lim,
					($urandom_range(7) == 0) ? LMIN : rand64());
			else
				push_item(OP_UNUSED, ch, rand64(), rand64(), dl, lim, rand64());
		end
	endtask

	initial begin
		longint start_vals[5];
		start_vals = '{0, LMAX, LMIN, 5 * ONE, -3 * ONE};
		for (int c = 0; c < 4; c++) begin
			chan_time[c] = 10 * ONE;
			chan_value[c] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty read, events, duplicates, rollback, windows, range errors
		push_item(OP_READ,   0, 2 * ONE, 77, ONE, 2 * ONE, 0);
		push_item(OP_STORE,  0, 1 * ONE, 10 * ONE, 4 * ONE, 4 * ONE, 0);
		push_item(OP_READ,   0, 2 * ONE, 5, 3 * ONE, 4 * ONE, 0);
		push_item(OP_STORE,  0, 2 * ONE, 20 * ONE, 4 * ONE, 4 * ONE, 0);
		push_item(OP_STORE,  0, 2 * ONE, 30 * ONE, 4 * ONE, 4 * ONE, 0);
		push_item(OP_STORE,  0, 2 * ONE, 30 * ONE, 4 * ONE, 4 * ONE, 0);
		push_item(OP_STORE,  0, 4 * ONE, 40 * ONE, 4 * ONE, 4 * ONE, 0);
		push_item(OP_ZC,     0, 5 * ONE, 0, 2 * ONE, 0, 12345);
		push_item(OP_ZC,     0, 5 * ONE, 0, 2 * ONE, 0, LMIN);
		push_item(OP_READ,   0, 6 * ONE, 50 * ONE, 2 * ONE, 3 * ONE, 0);
		push_item(OP_READ,   0, 6 * ONE, 50 * ONE, ONE + ONE / 2, 3 * ONE, 0);
		push_item(OP_READ,   0, 6 * ONE, 50 * ONE, ONE / 2, 3 * ONE, 0);
		push_item(OP_READ,   0, 6 * ONE, 50 * ONE, 0, 3 * ONE, 0);
		push_item(OP_READ,   0, 6 * ONE, 50 * ONE, 4 * ONE, 3 * ONE, 0);
		push_item(OP_READ,   0, -ONE, 9, ONE, ONE, 0);
		push_item(OP_STORE,  0, 3 * ONE, -7 * ONE, ONE, ONE, 0);
		push_item(OP_STORE,  1, LMAX, LMIN, D_MAX, D_MAX, 0);
		push_item(OP_STORE,  1, LMAX, LMAX, D_MAX, D_MAX, 0);
		push_item(OP_READ,   1, LMAX, LMIN, D_MAX, D_MAX, 0);
		push_item(OP_READ,   1, LMAX, LMAX, 63'd1, D_MAX, 0);
		push_item(OP_STORE,  2, LMIN, LMAX, 63'd1, 63'd0, LMAX);
		push_item(OP_READ,   2, LMIN + 1, LMIN, 63'd1, 63'd1, 0);
		push_item(OP_UNUSED, 3, LMAX, LMAX, D_MAX, D_MAX, LMAX);
		push_item(OP_ZC,     1, LMAX, 0, D_MAX, D_MAX, LMIN);

		for (int p = 0; p < 5; p++) begin
			write_start(start_vals[p]);
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 88; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 88; end
				default: begin send_idle = 16; recv_stall = 16; end
			endcase
			for (int i = 0; i < 160; i++) begin
				if (i == 60 && p == 1) begin
					hold_reqs = hold_reqs + 1;
					send_idle = 0;
				end
				if (i == 100) begin
					send_idle = (p % 4 == 1 || p % 4 == 3) ? send_idle : 0;
					recv_stall = (p % 4 >= 2) ? 0 : recv_stall;
				end
				random_item();
			end
			if (p == 2) begin
				// fill one channel past its depth so the oldest pairs get dropped
				drain();
				for (int i = 0; i < 260; i++)
					push_item(OP_STORE, 3, chan_time[3] + longint'(i + 1) * ONE,
						rand64(), D_MAX, D_MAX, 0);
				chan_time[3] = chan_time[3] + 260 * ONE;
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
